/* sv/svh_pkg.sv */
// ----------------------------------------------------------------------------
// svh_pkg
// Shared types and constants for the sorted value histogram unit.
// ----------------------------------------------------------------------------
package svh_pkg;

    localparam int CNT_BITS = 6;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    typedef struct packed {
        logic insert;
        logic shift;
        logic hit;
    } cell_ctrl_t;

endpackage

/* sv/svh_cell.sv */
// ----------------------------------------------------------------------------
// svh_cell
// One cell of the sorted insertion chain: holds a distinct value, its count
// and a used mark; shifts right on insertion and left while draining.
// ----------------------------------------------------------------------------
module svh_cell import svh_pkg::*; #(
    parameter int VALUE_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cell_ctrl_t                   ctrl,
    input  logic signed [VALUE_BITS-1:0] new_val,
    input  logic                         left_lt,
    input  logic signed [VALUE_BITS-1:0] left_val,
    input  logic [CNT_BITS-1:0]          left_cnt,
    input  logic                         left_used,
    input  logic signed [VALUE_BITS-1:0] right_val,
    input  logic [CNT_BITS-1:0]          right_cnt,
    input  logic                         right_used,
    output logic signed [VALUE_BITS-1:0] val,
    output logic [CNT_BITS-1:0]          cnt,
    output logic                         used,
    output logic                         lt,
    output logic                         eq
);

    logic signed [VALUE_BITS-1:0] val_reg, val_next;
    logic [CNT_BITS-1:0]          cnt_reg, cnt_next;
    logic                         used_reg, used_next;

    assign lt   = used_reg && (val_reg < new_val);
    assign eq   = used_reg && (val_reg == new_val);
    assign val  = val_reg;
    assign cnt  = cnt_reg;
    assign used = used_reg;

    always_comb begin
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        used_next = used_reg;
        if (ctrl.insert) begin
            if (ctrl.hit) begin
                if (eq) begin
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
            end else if (!lt) begin
                if (left_lt) begin
                    val_next  = new_val;
                    cnt_next  = CNT_BITS'(1);
                    used_next = 1'b1;
                end else begin
                    val_next  = left_val;
                    cnt_next  = left_cnt;
                    used_next = left_used;
                end
            end
        end else if (ctrl.shift) begin
            val_next  = right_val;
            cnt_next  = right_cnt;
            used_next = right_used;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else begin
            used_reg <= used_next;
        end
    end

endmodule

/* sv/sorted_value_histogram_unit.sv */
// ----------------------------------------------------------------------------
// sorted_value_histogram_unit
// Histogram of a signed list by sorted insertion and run-length count.
// ----------------------------------------------------------------------------
// List elements are taken one per cycle into a row of MAX_ITEMS cells that
// keeps distinct values in ascending order with their counts. A transfer
// with the final mark starts the drain: the row shifts toward cell 0 by one
// cell per output transfer, so a list with n distinct values yields n pairs,
// and the input stays stalled until the
// last pair has been loaded into the output register. Elements beyond
// MAX_ITEMS are discarded and flag every pair of that list as dropped.
module sorted_value_histogram_unit import svh_pkg::*; #(
    parameter int MAX_ITEMS  = 32,
    parameter int VALUE_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_value,
    input  logic                         s_final_element,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [VALUE_BITS-1:0] m_value_res,
    output logic [CNT_BITS-1:0]          m_occurrences,
    output logic                         m_last_pair,
    output logic                         m_dropped
);

    localparam int SEEN_BITS = $clog2(MAX_ITEMS + 1);

    state_t                       state_reg, state_next;
    logic [SEEN_BITS-1:0]         seen_reg, seen_next;
    logic                         ovf_reg, ovf_next;
    logic                         m_valid_reg, m_valid_next;
    logic signed [VALUE_BITS-1:0] m_val_reg;
    logic [CNT_BITS-1:0]          m_cnt_reg;
    logic                         m_last_reg, m_drop_reg;

    logic signed [VALUE_BITS-1:0] cell_val [MAX_ITEMS];
    logic [CNT_BITS-1:0]          cell_cnt [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]         cell_used, cell_lt, cell_eq;

    cell_ctrl_t ctrl;
    logic       in_xfer, room, out_free, emit;

    assign s_ready  = (state_reg == ST_LOAD);
    assign in_xfer  = s_valid && s_ready;
    assign room     = (seen_reg < SEEN_BITS'(MAX_ITEMS));
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (state_reg == ST_DRAIN) && out_free;

    assign ctrl.insert = in_xfer && room;
    assign ctrl.shift  = emit;
    assign ctrl.hit    = |cell_eq;

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        logic                         l_lt, l_used, r_used;
        logic signed [VALUE_BITS-1:0] l_val, r_val;
        logic [CNT_BITS-1:0]          l_cnt, r_cnt;

        if (i == 0) begin : g_first
            assign l_lt   = 1'b1;
            assign l_val  = '0;
            assign l_cnt  = '0;
            assign l_used = 1'b0;
        end else begin : g_mid
            assign l_lt   = cell_lt[i-1];
            assign l_val  = cell_val[i-1];
            assign l_cnt  = cell_cnt[i-1];
            assign l_used = cell_used[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_last
            assign r_val  = '0;
            assign r_cnt  = '0;
            assign r_used = 1'b0;
        end else begin : g_inner
            assign r_val  = cell_val[i+1];
            assign r_cnt  = cell_cnt[i+1];
            assign r_used = cell_used[i+1];
        end

        svh_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .new_val   (s_value),
            .left_lt   (l_lt),
            .left_val  (l_val),
            .left_cnt  (l_cnt),
            .left_used (l_used),
            .right_val (r_val),
            .right_cnt (r_cnt),
            .right_used(r_used),
            .val       (cell_val[i]),
            .cnt       (cell_cnt[i]),
            .used      (cell_used[i]),
            .lt        (cell_lt[i]),
            .eq        (cell_eq[i])
        );
    end

    always_comb begin
        state_next   = state_reg;
        seen_next    = seen_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (room) begin
                        seen_next = seen_reg + SEEN_BITS'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_final_element) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (emit) begin
                    m_valid_next = 1'b1;
                    if (!cell_used[1]) begin
                        state_next = ST_LOAD;
                        seen_next  = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_val_reg  <= cell_val[0];
            m_cnt_reg  <= cell_cnt[0];
            m_last_reg <= !cell_used[1];
            m_drop_reg <= ovf_reg;
        end
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            seen_reg    <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            seen_reg    <= seen_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_value_res   = m_val_reg;
    assign m_occurrences = m_cnt_reg;
    assign m_last_pair   = m_last_reg;
    assign m_dropped     = m_drop_reg;

endmodule

/* sv/svh_checker.sv */
// ----------------------------------------------------------------------------
// svh_checker
// Port-level checks for the sorted value histogram unit, bound to the top.
// ----------------------------------------------------------------------------
module svh_checker import svh_pkg::*; #(
    parameter int MAX_ITEMS  = 32,
    parameter int VALUE_BITS = 16
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic signed [VALUE_BITS-1:0] s_value,
    input logic                         s_final_element,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [VALUE_BITS-1:0] m_value_res,
    input logic [CNT_BITS-1:0]          m_occurrences,
    input logic                         m_last_pair,
    input logic                         m_dropped
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_res)
            && $stable(m_occurrences) && $stable(m_last_pair) && $stable(m_dropped))
        else $error("result changed while stalled");

    // a final element always starts a drain
    a_final_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_final_element |=> !s_ready)
        else $error("input not stalled after final element");

    // more pairs pending keeps the input closed
    a_mid_run_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_pair |-> !s_ready)
        else $error("input open in the middle of a run");

    // every emitted pair counts at least one element
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (MAX_ITEMS >= 64) || (m_occurrences != '0))
        else $error("pair with zero occurrences");

endmodule

bind sorted_value_histogram_unit svh_checker #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
) u_svh_checker (.*);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_value_histogram_unit: lists of signed values
// go in over the input channel, and every value/count pair that comes out is
// checked against a histogram kept alongside the block, including lists that
// overrun the block's capacity. Both channels idle at random until CALM_FROM elements are sent.
// ----------------------------------------------------------------------------
module testbench;
    import svh_pkg::*;

    localparam int MAX_ITEMS  = 32;
    localparam int VALUE_BITS = 16;
    localparam int ITEM_TARGET = 420;
    localparam int CALM_FROM   = 360;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        value_t              value;
        logic [CNT_BITS-1:0] occurrences;
        logic                last_pair;
        logic                dropped;
    } pair_t;

    class histogram_scoreboard;
        value_t bin_value [MAX_ITEMS];
        int     bin_count [MAX_ITEMS];
        int     bins_used;
        int     kept;
        bit     overflow;
        pair_t  expected_pairs [$];
        int     errors;

        function new();
            bins_used = 0;
            kept      = 0;
            overflow  = 0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        function void note_element(value_t v, logic fin);
            int    pos;
            int    k;
            pair_t p;
            if (kept < MAX_ITEMS) begin
                pos = 0;
                while (pos < bins_used && bin_value[pos] < v)
                    pos++;
                if (pos < bins_used && bin_value[pos] == v) begin
                    bin_count[pos]++;
                end else begin
                    for (k = bins_used; k > pos; k--) begin
                        bin_value[k] = bin_value[k-1];
                        bin_count[k] = bin_count[k-1];
                    end
                    bin_value[pos] = v;
                    bin_count[pos] = 1;
                    bins_used++;
                end
                kept++;
            end else begin
                overflow = 1;
            end
            if (fin) begin
                for (k = 0; k < bins_used; k++) begin
                    p.value       = bin_value[k];
                    p.occurrences = bin_count[k][CNT_BITS-1:0];
                    p.last_pair   = (k == bins_used - 1);
                    p.dropped     = overflow;
                    expected_pairs.push_back(p);
                end
                bins_used = 0;
                kept      = 0;
                overflow  = 0;
            end
        endfunction

        function void check_pair(pair_t got);
            pair_t want;
            if (expected_pairs.size() == 0) begin
                $display("%0t: unexpected pair value=%0d occ=%0d last=%0b dropped=%0b",
                         $time, got.value, got.occurrences, got.last_pair, got.dropped);
                errors++;
            end else begin
                want = expected_pairs.pop_front();
                if (got !== want) begin
                    $display("%0t: expected %0d/%0d/%0b/%0b, actual %0d/%0d/%0b/%0b",
                             $time, want.value, want.occurrences, want.last_pair,
                             want.dropped, got.value, got.occurrences, got.last_pair,
                             got.dropped);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    value_t              s_value;
    logic                s_final_element;
    logic                m_valid;
    logic                m_ready;
    value_t              m_value_res;
    logic [CNT_BITS-1:0] m_occurrences;
    logic                m_last_pair;
    logic                m_dropped;

    histogram_scoreboard board = new();
    value_t list_buf [$];
    int     items_sent;
    bit     calm;

    sorted_value_histogram_unit #(
        .MAX_ITEMS (MAX_ITEMS),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_final_element(s_final_element),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value_res    (m_value_res),
        .m_occurrences  (m_occurrences),
        .m_last_pair    (m_last_pair),
        .m_dropped      (m_dropped)
    );

    initial aclk = 0;
    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            board.note_element(s_value, s_final_element);
        if (aresetn && m_valid && m_ready)
            board.check_pair({m_value_res, m_occurrences, m_last_pair, m_dropped});
    end

    // one element transfer, entered and left at a falling edge
    task automatic send_element(value_t v, logic fin);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid = 0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid         = 1;
        s_value         = v;
        s_final_element = fin;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        calm = (items_sent >= CALM_FROM);
        @(negedge aclk);
    endtask

    task automatic send_list();
        int i;
        for (i = 0; i < list_buf.size(); i++)
            send_element(list_buf[i], i == list_buf.size() - 1);
    endtask

    task automatic build_random_list(int list_no);
        int     kind;
        int     len;
        int     i;
        value_t base;
        kind = (list_no < 3) ? 7 + list_no : $urandom_range(0, 9);
        base = value_t'($urandom);
        list_buf.delete();
        case (kind)
            6: len = $urandom_range(1, 24);
            7, 9: len = MAX_ITEMS;
            8: len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
            default: len = $urandom_range(1, 16);
        endcase
        for (i = 0; i < len; i++) begin
            case (kind)
                6: list_buf.push_back(value_t'($urandom));
                9: list_buf.push_back(base);
                8: list_buf.push_back($urandom_range(0, 1) ? value_t'($urandom)
                                      : value_t'(base + $urandom_range(0, 5)));
                default: list_buf.push_back(value_t'(base + $urandom_range(0, 7)));
            endcase
        end
    endtask

    initial begin
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready = 0;
                repeat ($urandom_range(0, 4)) @(negedge aclk);
            end else begin
                m_ready = 1;
            end
        end
    end

    initial begin
        int list_no;
        aresetn         = 0;
        s_valid         = 0;
        s_value         = '0;
        s_final_element = 0;
        items_sent      = 0;
        calm            = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // single-element lists at both extremes
        list_buf = '{16'sh8000};
        send_list();
        list_buf = '{16'sh7fff};
        send_list();
        list_buf = '{16'sh0000, 16'shffff, 16'sh7fff, 16'sh8000,
                     16'sh0001, 16'shffff, 16'sh0000, 16'sh7fff};
        send_list();
        list_buf = '{16'sh0007, 16'sh0007};
        send_list();
        // descending order forces insertion at the head
        list_buf = '{16'sh0003, 16'sh0002, 16'sh0001, 16'shfffe};
        send_list();

        list_no = 0;
        while (items_sent < ITEM_TARGET) begin
            build_random_list(list_no);
            send_list();
            list_no++;
        end
        s_valid = 0;

        while (board.pending() != 0)
            @(posedge aclk);
        repeat (MAX_ITEMS + 8) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial begin
        #800000;
        $display("testbench failed");
        $finish;
    end

endmodule
